// ===== rtl/utc_pkg.sv =====
// ----------------------------------------------------------------------------
// Uptime clock package
// Shared types and constants for the uptime clock controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package utc_pkg;

    localparam int CYC_W    = 32;
    localparam int TOTAL_W  = 64;
    localparam int START_W  = 64;
    localparam int DUR_W    = 32;
    localparam int HZ_W     = 32;
    localparam int MULT_W   = 10;
    localparam int PROD_W   = TOTAL_W + MULT_W;
    localparam int NOW_W    = 64;
    localparam int WRAP_W   = 32;
    localparam int HUND_W   = 7;
    localparam int SEC_W    = 6;
    localparam int MIN_W    = 6;
    localparam int HOUR_W   = 5;
    localparam int DAY_W    = 38;
    localparam int MSR_W    = 10;
    localparam int CNT_W    = 7;

    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 160;

    localparam logic [MULT_W-1:0] MS_PER_S  = MULT_W'(1000);
    localparam logic [MSR_W:0]    MS_MOD    = (MSR_W + 1)'(1000);
    localparam logic [SEC_W:0]    SEC_MOD   = (SEC_W + 1)'(60);
    localparam logic [MIN_W:0]    MIN_MOD   = (MIN_W + 1)'(60);
    localparam logic [HOUR_W:0]   HOUR_MOD  = (HOUR_W + 1)'(24);
    localparam logic [7:0]        DIV10_MUL = 8'd205;
    localparam int                DIV10_SHR = 11;

    localparam logic [HZ_W-1:0]  HZ_RESET  = HZ_W'(1000000);

    // The quotient has PROD_W bits; only the low NOW_W are kept.
    localparam logic [CNT_W-1:0] DROP_BITS = CNT_W'(PROD_W - NOW_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(PROD_W - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic step;
        logic feed;
        logic out_load;
    } dp_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/utc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Uptime clock controller
// Sequences accept, multiply, serial division and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module utc_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output utc_pkg::dp_cmd_t     cmd
);
    import utc_pkg::*;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd           = '0;
        s_tready      = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                count_next = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.step   = 1'b1;
                cmd.feed   = (count_reg >= DROP_BITS);
                count_next = count_reg + CNT_W'(1);
                if (count_reg == LAST_STEP) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

// ===== rtl/utc_datapath.sv =====
// ----------------------------------------------------------------------------
// Uptime clock datapath
// Cycle total, millisecond product, restoring divider and time breakdown.
// ----------------------------------------------------------------------------
`default_nettype none

module utc_datapath (
    input  wire logic                          aclk,
    input  wire utc_pkg::dp_cmd_t              cmd,
    input  wire logic                          aresetn,
    input  wire logic [utc_pkg::HZ_W-1:0]      clock_hz,
    input  wire logic [utc_pkg::IN_DATA_W-1:0] s_tdata,
    output logic      [utc_pkg::OUT_DATA_W-1:0] m_tdata
);
    import utc_pkg::*;

    logic [TOTAL_W-1:0]  total_reg;
    logic [START_W:0]    sum_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [HZ_W-1:0]     rem_reg;
    logic [NOW_W-1:0]    now_reg;
    logic [MSR_W-1:0]    ms_reg;
    logic [SEC_W-1:0]    sec_reg;
    logic [MIN_W-1:0]    min_reg;
    logic [HOUR_W-1:0]   hour_reg;
    logic [DAY_W-1:0]    day_reg;
    logic [OUT_DATA_W-1:0] out_reg;

    logic [CYC_W-1:0]    in_cyc;
    logic [START_W-1:0]  in_start;
    logic [DUR_W-1:0]    in_dur;

    logic [HZ_W:0]       trial;
    logic                q_bit;
    logic [HZ_W-1:0]     rem_next;
    logic [MSR_W:0]      ms_x;
    logic [SEC_W:0]      sec_x;
    logic [MIN_W:0]      min_x;
    logic [HOUR_W:0]     hour_x;
    logic                c_ms, c_sec, c_min, c_hour;
    logic [MSR_W+7:0]    hund_prod;
    logic                expired;

    assign in_cyc   = s_tdata[CYC_W-1:0];
    assign in_start = s_tdata[CYC_W+START_W-1:CYC_W];
    assign in_dur   = s_tdata[CYC_W+START_W+DUR_W-1:CYC_W+START_W];

    // One restoring step: the partial remainder never exceeds the divisor,
    // so a 33-bit trial value is enough.
    always_comb begin
        trial = {rem_reg, prod_reg[PROD_W-1]};
        q_bit = (trial >= {1'b0, clock_hz});
        if (q_bit) begin
            rem_next = HZ_W'(trial - {1'b0, clock_hz});
        end else begin
            rem_next = trial[HZ_W-1:0];
        end
    end

    // Quotient bits arrive most significant first, so they pass through a
    // chain of small serial dividers: each stage's quotient bit feeds the next.
    always_comb begin
        ms_x   = {ms_reg, q_bit};
        c_ms   = (ms_x >= MS_MOD);
        sec_x  = {sec_reg, c_ms};
        c_sec  = (sec_x >= SEC_MOD);
        min_x  = {min_reg, c_sec};
        c_min  = (min_x >= MIN_MOD);
        hour_x = {hour_reg, c_min};
        c_hour = (hour_x >= HOUR_MOD);
    end

    assign hund_prod = (MSR_W + 8)'(ms_reg) * (MSR_W + 8)'(DIV10_MUL);
    assign expired   = !sum_reg[START_W] && (sum_reg[START_W-1:0] < now_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
        end else if (cmd.load) begin
            total_reg <= total_reg + TOTAL_W'(in_cyc);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sum_reg <= (START_W + 1)'(in_start) + (START_W + 1)'(in_dur);
        end
        if (cmd.mul) begin
            prod_reg <= PROD_W'(total_reg) * PROD_W'(MS_PER_S);
            rem_reg  <= '0;
            ms_reg   <= '0;
            sec_reg  <= '0;
            min_reg  <= '0;
            hour_reg <= '0;
            day_reg  <= '0;
        end
        if (cmd.step) begin
            prod_reg <= {prod_reg[PROD_W-2:0], 1'b0};
            rem_reg  <= rem_next;
            now_reg  <= {now_reg[NOW_W-2:0], q_bit};
        end
        if (cmd.step && cmd.feed) begin
            ms_reg   <= c_ms   ? MSR_W'(ms_x - MS_MOD)      : ms_x[MSR_W-1:0];
            sec_reg  <= c_sec  ? SEC_W'(sec_x - SEC_MOD)    : sec_x[SEC_W-1:0];
            min_reg  <= c_min  ? MIN_W'(min_x - MIN_MOD)    : min_x[MIN_W-1:0];
            hour_reg <= c_hour ? HOUR_W'(hour_x - HOUR_MOD) : hour_x[HOUR_W-1:0];
            day_reg  <= {day_reg[DAY_W-2:0], c_hour};
        end
        if (cmd.out_load) begin
            out_reg <= {1'b0,
                        day_reg,
                        hour_reg,
                        min_reg,
                        sec_reg,
                        hund_prod[DIV10_SHR+HUND_W-1:DIV10_SHR],
                        expired,
                        total_reg[TOTAL_W-1:TOTAL_W-WRAP_W],
                        now_reg};
        end
    end

    assign m_tdata = out_reg;

endmodule

`default_nettype wire

// ===== rtl/uptime_clock_with_timer_check.sv =====
// ----------------------------------------------------------------------------
// Uptime clock with timer check
// Running cycle total, uptime in milliseconds, timer expiry and breakdown.
// ----------------------------------------------------------------------------
// Each input beat carries the cycles elapsed since the previous beat and a
// timer (start and duration in milliseconds); each one yields exactly one
// output beat. The block keeps a 64-bit cycle total, multiplies it by 1000
// and divides the 74-bit product by clock_hz with a bit-serial restoring
// divider, one quotient bit per cycle. The cycle total is updated at the
// edge that accepts a beat; then come the multiply, one divider step per
// product bit and the output register load, which waits while the previous
// result is still not taken. A new beat is accepted only once the block is
// back in idle, so the divider loop sets the rate.
// Milliseconds, seconds, minutes, hours and days are formed on the fly as
// the quotient bits emerge; hundredths come from the millisecond remainder.
// A new input beat is taken while the previous result still waits on
// m_tready. A clock_hz of zero gives an all-ones uptime. clock_hz must
// only be written while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module uptime_clock_with_timer_check (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    // Configuration: clock rate in cycles per second.
    input  wire logic                            cfg_we,
    input  wire logic [utc_pkg::HZ_W-1:0]        cfg_wdata,

    // Input channel.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // Fields from bit 0 up: cycles_elapsed[31:0], timer_start_ms[63:0],
    // timer_duration_ms[31:0].
    input  wire logic [utc_pkg::IN_DATA_W-1:0]   s_tdata,

    // Result channel.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // Fields from bit 0 up: now_ms[63:0], cycle_wraps[31:0], expired,
    // hundredths[6:0], seconds[5:0], minutes[5:0], hours[4:0], days[37:0],
    // then one zero pad bit.
    output logic      [utc_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import utc_pkg::*;

    logic [HZ_W-1:0] clock_hz_reg;
    dp_cmd_t         cmd;

    // The clock rate register is the only configuration state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_hz_reg <= HZ_RESET;
        end else if (cfg_we) begin
            clock_hz_reg <= cfg_wdata;
        end
    end

    // The controller owns the handshakes and the step counter.
    utc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // The datapath holds the total, divider, breakdown and output register.
    utc_datapath u_datapath (
        .aclk     (aclk),
        .cmd      (cmd),
        .aresetn  (aresetn),
        .clock_hz (clock_hz_reg),
        .s_tdata  (s_tdata),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
